// ----- sv/cfts_pkg.sv -----
// Shared widths, codes and transaction types for the cube map texel select block.
`default_nettype none
package cfts_pkg;

    localparam int DIR_W          = 16;
    localparam int MAG_W          = DIR_W + 1;
    localparam int MIP_W          = 4;
    localparam int FW_W           = 13;
    localparam int MC_W           = 5;
    localparam int TEX_W          = 12;
    localparam int IDX_W          = 24;
    localparam int FACE_CODE_W    = 3;
    localparam int STAT_W         = 2;
    localparam int MAX_FACE_WIDTH = 4096;
    localparam int MAX_MIP_LEVELS = 16;
    localparam int FACE_WIDTH_RST = 256;
    localparam int MIP_COUNT_RST  = 1;

    // quotient bits, numerator and denominator widths of the coordinate divide
    localparam int Q_W     = FW_W;
    localparam int NUM_W   = 29;
    localparam int DEN_W   = MAG_W + 1;
    localparam int TRIAL_W = DEN_W + Q_W - 1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = FW_W;

    localparam logic [CFG_IDX_W-1:0] REG_FACE_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MIP_COUNT  = 1'b1;

    localparam logic [FACE_CODE_W-1:0] FACE_PX = 3'd0;
    localparam logic [FACE_CODE_W-1:0] FACE_NX = 3'd1;
    localparam logic [FACE_CODE_W-1:0] FACE_PY = 3'd2;
    localparam logic [FACE_CODE_W-1:0] FACE_NY = 3'd3;
    localparam logic [FACE_CODE_W-1:0] FACE_PZ = 3'd4;
    localparam logic [FACE_CODE_W-1:0] FACE_NZ = 3'd5;

    localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_ZERO = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_MIP  = 2'd2;

    typedef struct packed {
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
        logic [MIP_W-1:0]        mip_level;
    } cfts_req_t;

    typedef struct packed {
        logic [FACE_CODE_W-1:0] face;
        logic [TEX_W-1:0]       tex_x;
        logic [TEX_W-1:0]       tex_y;
        logic [IDX_W-1:0]       texel_index;
        logic [STAT_W-1:0]      status;
    } cfts_rsp_t;

    typedef struct packed {
        logic [NUM_W-1:0]       num_u;
        logic [NUM_W-1:0]       num_v;
        logic [DEN_W-1:0]       den;
        logic [FACE_CODE_W-1:0] face;
        logic [STAT_W-1:0]      status;
    } cfts_num_t;

    typedef struct packed {
        logic [Q_W-1:0]         q_u;
        logic [Q_W-1:0]         q_v;
        logic [FACE_CODE_W-1:0] face;
        logic [STAT_W-1:0]      status;
    } cfts_quo_t;

endpackage
`default_nettype wire

// ----- sv/cubemap_face_texel_select.sv -----
// Pipeline: 18 register stages from request acceptance to rsp_valid (3 front,
// 13 divider, 2 back); the divider contributes one quotient bit per stage.
// Throughput: one transaction per cycle; each stage holds when the one after it is full.
// Reset: rst_n clears all stage valids; face_width returns to 256 and mip_count to 1.
// Config writes are taken every cycle and must only occur while the pipeline is empty.
`default_nettype none
module cubemap_face_texel_select (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [cfts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cfts_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              req_valid,
    output logic                                   req_ready,
    input  wire cfts_pkg::cfts_req_t               req,
    output logic                                   rsp_valid,
    input  wire logic                              rsp_ready,
    output cfts_pkg::cfts_rsp_t                    rsp
);
    import cfts_pkg::*;

    logic [FW_W-1:0] face_width_reg, face_width_next;
    logic [MC_W-1:0] mip_count_reg, mip_count_next;

    logic      num_valid, num_ready;
    cfts_num_t num;
    logic      quo_valid, quo_ready;
    cfts_quo_t quo;

    assign cfg_ready = 1'b1;

    // registers hold the clamped values actually used
    always_comb
    begin
        face_width_next = face_width_reg;
        mip_count_next  = mip_count_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FACE_WIDTH:
                begin
                    if (cfg_data == '0)
                        face_width_next = FW_W'(1);
                    else if (cfg_data > CFG_DATA_W'(MAX_FACE_WIDTH))
                        face_width_next = FW_W'(MAX_FACE_WIDTH);
                    else
                        face_width_next = cfg_data;
                end
                REG_MIP_COUNT:
                begin
                    if (cfg_data[MC_W-1:0] > MC_W'(MAX_MIP_LEVELS))
                        mip_count_next = MC_W'(MAX_MIP_LEVELS);
                    else
                        mip_count_next = cfg_data[MC_W-1:0];
                end
                default:
                begin
                    face_width_next = face_width_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face_width_reg <= FW_W'(FACE_WIDTH_RST);
            mip_count_reg  <= MC_W'(MIP_COUNT_RST);
        end
        else
        begin
            face_width_reg <= face_width_next;
            mip_count_reg  <= mip_count_next;
        end
    end

    cfts_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .face_w    (face_width_reg),
        .mip_cnt   (mip_count_reg),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .num_valid (num_valid),
        .num_ready (num_ready),
        .num       (num)
    );

    cfts_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .num_valid (num_valid),
        .num_ready (num_ready),
        .num       (num),
        .quo_valid (quo_valid),
        .quo_ready (quo_ready),
        .quo       (quo)
    );

    cfts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .face_w    (face_width_reg),
        .quo_valid (quo_valid),
        .quo_ready (quo_ready),
        .quo       (quo),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire

// ----- sv/cfts_front.sv -----
// Front stages: magnitudes, major axis and face, face-plane offsets, numerator products.
`default_nettype none
module cfts_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [cfts_pkg::FW_W-1:0]   face_w,
    input  wire logic [cfts_pkg::MC_W-1:0]   mip_cnt,
    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire cfts_pkg::cfts_req_t         req,
    output logic                             num_valid,
    input  wire logic                        num_ready,
    output cfts_pkg::cfts_num_t              num
);
    import cfts_pkg::*;

    typedef struct packed {
        logic signed [DIR_W-1:0] dx;
        logic signed [DIR_W-1:0] dy;
        logic signed [DIR_W-1:0] dz;
        logic [MAG_W-1:0]        ax;
        logic [MAG_W-1:0]        ay;
        logic [MAG_W-1:0]        az;
        logic                    mip_bad;
    } sta_t;

    typedef struct packed {
        logic [MAG_W-1:0]       un;
        logic [MAG_W-1:0]       vn;
        logic [MAG_W-1:0]       m;
        logic [FACE_CODE_W-1:0] face;
        logic [STAT_W-1:0]      status;
    } stb_t;

    function automatic logic [MAG_W-1:0] abs_mag(input logic signed [DIR_W-1:0] d);
        logic signed [MAG_W-1:0] e;
        begin
            e = MAG_W'(d);
            return d[DIR_W-1] ? MAG_W'(-e) : MAG_W'(e);
        end
    endfunction

    sta_t      a_reg, a_next;
    stb_t      b_reg, b_next;
    cfts_num_t c_reg, c_next;
    logic      a_v_reg, b_v_reg, c_v_reg;
    logic      adv_a, adv_b, adv_c;

    assign adv_c     = !c_v_reg || num_ready;
    assign adv_b     = !b_v_reg || adv_c;
    assign adv_a     = !a_v_reg || adv_b;
    assign req_ready = adv_a;
    assign num_valid = c_v_reg;
    assign num       = c_reg;

    // stage A
    always_comb
    begin
        a_next.dx      = req.dir_x;
        a_next.dy      = req.dir_y;
        a_next.dz      = req.dir_z;
        a_next.ax      = abs_mag(req.dir_x);
        a_next.ay      = abs_mag(req.dir_y);
        a_next.az      = abs_mag(req.dir_z);
        a_next.mip_bad = {1'b0, req.mip_level} >= mip_cnt;
    end

    // stage B: major axis, face, offsets c + m
    logic [MAG_W-1:0]         m;
    logic signed [DIR_W-1:0]  sel_u, sel_v;
    logic                     neg_u, neg_v;
    logic signed [MAG_W:0]    m_s, un_s, vn_s;

    always_comb
    begin
        m = a_reg.ax;
        if (a_reg.ay > m)
            m = a_reg.ay;
        if (a_reg.az > m)
            m = a_reg.az;

        priority if (a_reg.ax == m)
            b_next.face = a_reg.dx[DIR_W-1] ? FACE_NX : FACE_PX;
        else if (a_reg.ay == m)
            b_next.face = a_reg.dy[DIR_W-1] ? FACE_NY : FACE_PY;
        else
            b_next.face = a_reg.dz[DIR_W-1] ? FACE_NZ : FACE_PZ;

        unique case (b_next.face)
            FACE_PX: begin sel_u = a_reg.dz; neg_u = 1'b1; sel_v = a_reg.dy; neg_v = 1'b1; end
            FACE_NX: begin sel_u = a_reg.dz; neg_u = 1'b0; sel_v = a_reg.dy; neg_v = 1'b1; end
            FACE_PY: begin sel_u = a_reg.dx; neg_u = 1'b0; sel_v = a_reg.dz; neg_v = 1'b0; end
            FACE_NY: begin sel_u = a_reg.dx; neg_u = 1'b0; sel_v = a_reg.dz; neg_v = 1'b1; end
            FACE_PZ: begin sel_u = a_reg.dx; neg_u = 1'b0; sel_v = a_reg.dy; neg_v = 1'b1; end
            FACE_NZ: begin sel_u = a_reg.dx; neg_u = 1'b1; sel_v = a_reg.dy; neg_v = 1'b1; end
            default: begin sel_u = a_reg.dx; neg_u = 1'b0; sel_v = a_reg.dy; neg_v = 1'b0; end
        endcase

        m_s  = {1'b0, m};
        un_s = neg_u ? m_s - (MAG_W+1)'(sel_u) : m_s + (MAG_W+1)'(sel_u);
        vn_s = neg_v ? m_s - (MAG_W+1)'(sel_v) : m_s + (MAG_W+1)'(sel_v);

        b_next.un = un_s[MAG_W-1:0];
        b_next.vn = vn_s[MAG_W-1:0];
        b_next.m  = m;

        priority if (a_reg.mip_bad)
            b_next.status = STATUS_MIP;
        else if (m == '0)
            b_next.status = STATUS_ZERO;
        else
            b_next.status = STATUS_OK;
    end

    // stage C: (c + m) * (W + 1), denominator 2m
    logic [NUM_W-1:0] wp1;

    always_comb
    begin
        wp1           = NUM_W'(face_w) + NUM_W'(1);
        c_next.num_u  = NUM_W'(b_reg.un) * wp1;
        c_next.num_v  = NUM_W'(b_reg.vn) * wp1;
        c_next.den    = {b_reg.m, 1'b0};
        c_next.face   = b_reg.face;
        c_next.status = b_reg.status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end
        else
        begin
            if (adv_a)
                a_v_reg <= req_valid;
            if (adv_b)
                b_v_reg <= a_v_reg;
            if (adv_c)
                c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_a && req_valid)
            a_reg <= a_next;
        if (adv_b && a_v_reg)
            b_reg <= b_next;
        if (adv_c && b_v_reg)
            c_reg <= c_next;
    end

endmodule
`default_nettype wire

// ----- sv/cfts_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing a divisor.
`default_nettype none
module cfts_div (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 num_valid,
    output logic                      num_ready,
    input  wire cfts_pkg::cfts_num_t  num,
    output logic                      quo_valid,
    input  wire logic                 quo_ready,
    output cfts_pkg::cfts_quo_t       quo
);
    import cfts_pkg::*;

    typedef struct packed {
        logic [NUM_W-1:0]       rem_u;
        logic [NUM_W-1:0]       rem_v;
        logic [Q_W-1:0]         q_u;
        logic [Q_W-1:0]         q_v;
        logic [DEN_W-1:0]       den;
        logic [FACE_CODE_W-1:0] face;
        logic [STAT_W-1:0]      status;
    } div_st_t;

    div_st_t st_reg  [Q_W];
    div_st_t st_next [Q_W];
    div_st_t src     [Q_W];
    logic    src_v   [Q_W];
    logic    v_reg   [Q_W];
    logic    adv     [Q_W+1];

    assign adv[Q_W]  = quo_ready;
    assign num_ready = adv[0];
    assign quo_valid = v_reg[Q_W-1];

    always_comb
    begin
        quo.q_u    = st_reg[Q_W-1].q_u;
        quo.q_v    = st_reg[Q_W-1].q_v;
        quo.face   = st_reg[Q_W-1].face;
        quo.status = st_reg[Q_W-1].status;
    end

    always_comb
    begin
        src[0].rem_u  = num.num_u;
        src[0].rem_v  = num.num_v;
        src[0].q_u    = '0;
        src[0].q_v    = '0;
        src[0].den    = num.den;
        src[0].face   = num.face;
        src[0].status = num.status;
        src_v[0]      = num_valid;
    end

    genvar k;
    generate
        for (k = 1; k < Q_W; k++)
        begin : g_link
            assign src[k]   = st_reg[k-1];
            assign src_v[k] = v_reg[k-1];
        end

        for (k = 0; k < Q_W; k++)
        begin : g_stage
            logic [TRIAL_W-1:0] trial;
            div_st_t            nxt;

            assign adv[k] = !v_reg[k] || adv[k+1];

            // quotient bit Q_W-1-k: subtract den shifted into that position
            always_comb
            begin
                trial = TRIAL_W'(src[k].den) << (Q_W - 1 - k);
                nxt   = src[k];
                if (TRIAL_W'(src[k].rem_u) >= trial)
                begin
                    nxt.rem_u            = NUM_W'(TRIAL_W'(src[k].rem_u) - trial);
                    nxt.q_u[Q_W - 1 - k] = 1'b1;
                end
                if (TRIAL_W'(src[k].rem_v) >= trial)
                begin
                    nxt.rem_v            = NUM_W'(TRIAL_W'(src[k].rem_v) - trial);
                    nxt.q_v[Q_W - 1 - k] = 1'b1;
                end
                st_next[k] = nxt;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[k] <= 1'b0;
                else if (adv[k])
                    v_reg[k] <= src_v[k];
            end

            always_ff @(posedge clk)
            begin
                if (adv[k] && src_v[k])
                    st_reg[k] <= st_next[k];
            end
        end
    endgenerate

endmodule
`default_nettype wire

// ----- sv/cfts_back.sv -----
// Back stages: clamp to the face, row-major texel index, result register.
`default_nettype none
module cfts_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [cfts_pkg::FW_W-1:0]  face_w,
    input  wire logic                       quo_valid,
    output logic                            quo_ready,
    input  wire cfts_pkg::cfts_quo_t        quo,
    output logic                            rsp_valid,
    input  wire logic                       rsp_ready,
    output cfts_pkg::cfts_rsp_t             rsp
);
    import cfts_pkg::*;

    typedef struct packed {
        logic [TEX_W-1:0]       tx;
        logic [TEX_W-1:0]       ty;
        logic [FACE_CODE_W-1:0] face;
        logic [STAT_W-1:0]      status;
    } tex_t;

    tex_t      d_reg, d_next;
    cfts_rsp_t rsp_reg, rsp_next;
    logic      d_v_reg, rsp_v_reg;
    logic      adv_d, adv_e;
    logic [FW_W-1:0]         w_m1;
    logic [TEX_W+FW_W-1:0]   idx_full;

    assign adv_e     = !rsp_v_reg || rsp_ready;
    assign adv_d     = !d_v_reg || adv_e;
    assign quo_ready = adv_d;
    assign rsp_valid = rsp_v_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        w_m1          = face_w - FW_W'(1);
        d_next.tx     = (quo.q_u >= face_w) ? w_m1[TEX_W-1:0] : quo.q_u[TEX_W-1:0];
        d_next.ty     = (quo.q_v >= face_w) ? w_m1[TEX_W-1:0] : quo.q_v[TEX_W-1:0];
        d_next.face   = quo.face;
        d_next.status = quo.status;
    end

    always_comb
    begin
        idx_full = (TEX_W+FW_W)'(d_reg.ty) * (TEX_W+FW_W)'(face_w)
                 + (TEX_W+FW_W)'(d_reg.tx);
        rsp_next.status = d_reg.status;
        if (d_reg.status == STATUS_OK)
        begin
            rsp_next.face        = d_reg.face;
            rsp_next.tex_x       = d_reg.tx;
            rsp_next.tex_y       = d_reg.ty;
            rsp_next.texel_index = idx_full[IDX_W-1:0];
        end
        else
        begin
            rsp_next.face        = '0;
            rsp_next.tex_x       = '0;
            rsp_next.tex_y       = '0;
            rsp_next.texel_index = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_v_reg   <= 1'b0;
            rsp_v_reg <= 1'b0;
        end
        else
        begin
            if (adv_d)
                d_v_reg <= quo_valid;
            if (adv_e)
                rsp_v_reg <= d_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_d && quo_valid)
            d_reg <= d_next;
        if (adv_e && d_v_reg)
            rsp_reg <= rsp_next;
    end

    a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != STATUS_OK |->
            rsp.face == '0 && rsp.tex_x == '0 && rsp.tex_y == '0 && rsp.texel_index == '0)
        else $error("error transaction carries nonzero result fields");

    a_tex_in_face: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == STATUS_OK |->
            {1'b0, rsp.tex_x} < face_w && {1'b0, rsp.tex_y} < face_w)
        else $error("texel coordinate outside the face");

    a_face_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == STATUS_OK |-> rsp.face <= FACE_NZ)
        else $error("face code out of range on a good transaction");

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for the cube map face select and texel address block.
`timescale 1ns / 1ps
module tb;
    import cfts_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int SETTLE_WAIT = 40;

    typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_PERIODIC, RDY_SPARSE} ready_mode_t;

    typedef struct {
        cfts_req_t src;
        cfts_rsp_t want;
    } texel_entry_t;

    class texel_scoreboard;
        texel_entry_t pending_texels[$];
        int unsigned  fw_reg = FACE_WIDTH_RST;
        int unsigned  mc_reg = MIP_COUNT_RST;
        int           errors = 0;

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        function int unsigned face_coord(int c, int mag, int unsigned w);
            longint num;
            longint q;
            num = longint'(c + mag) * longint'(w + 1);
            q = num / (longint'(mag) * 2);
            return (q >= longint'(w)) ? w - 1 : q;
        endfunction

        function cfts_rsp_t predict_texel(cfts_req_t r);
            cfts_rsp_t   o;
            int unsigned w;
            int unsigned mc;
            int          d[3];
            int          a[3];
            int          mag;
            int          axis;
            int          cu;
            int          cv;
            int unsigned tu;
            int unsigned tv;
            o  = '0;
            w  = fw_reg;
            mc = mc_reg;
            if (w == 0)
                w = 1;
            if (w > MAX_FACE_WIDTH)
                w = MAX_FACE_WIDTH;
            if (mc > MAX_MIP_LEVELS)
                mc = MAX_MIP_LEVELS;
            // mip range check wins over the zero-direction check
            if (r.mip_level >= mc)
            begin
                o.status = STATUS_MIP;
                return o;
            end
            d[0] = $signed(r.dir_x);
            d[1] = $signed(r.dir_y);
            d[2] = $signed(r.dir_z);
            for (int i = 0; i < 3; i++)
                a[i] = (d[i] < 0) ? -d[i] : d[i];
            mag = a[0];
            if (a[1] > mag)
                mag = a[1];
            if (a[2] > mag)
                mag = a[2];
            if (mag == 0)
            begin
                o.status = STATUS_ZERO;
                return o;
            end
            if (a[0] == mag)
                axis = 0;
            else if (a[1] == mag)
                axis = 1;
            else
                axis = 2;
            case (axis)
                0:       o.face = (d[0] < 0) ? FACE_NX : FACE_PX;
                1:       o.face = (d[1] < 0) ? FACE_NY : FACE_PY;
                default: o.face = (d[2] < 0) ? FACE_NZ : FACE_PZ;
            endcase
            case (o.face)
                FACE_PX: begin cu = -d[2]; cv = -d[1]; end
                FACE_NX: begin cu =  d[2]; cv = -d[1]; end
                FACE_PY: begin cu =  d[0]; cv =  d[2]; end
                FACE_NY: begin cu =  d[0]; cv = -d[2]; end
                FACE_PZ: begin cu =  d[0]; cv = -d[1]; end
                default: begin cu = -d[0]; cv = -d[1]; end
            endcase
            tu = face_coord(cu, mag, w);
            tv = face_coord(cv, mag, w);
            o.tex_x       = TEX_W'(tu);
            o.tex_y       = TEX_W'(tv);
            o.texel_index = IDX_W'(tv * w + tu);
            o.status      = STATUS_OK;
            return o;
        endfunction

        function void note_request(cfts_req_t r);
            texel_entry_t e;
            e.src  = r;
            e.want = predict_texel(r);
            pending_texels.push_back(e);
        endfunction

        function int pending();
            return pending_texels.size();
        endfunction

        task check_response(cfts_rsp_t got);
            texel_entry_t e;
            string        tag;
            if (pending_texels.size() == 0)
            begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            e   = pending_texels.pop_front();
            tag = $sformatf("dir (%0d,%0d,%0d) mip %0d W %0d MC %0d", e.src.dir_x,
                            e.src.dir_y, e.src.dir_z, e.src.mip_level, fw_reg, mc_reg);
            if (got.face !== e.want.face)
                report($sformatf("%s face %0d exp %0d", tag, got.face, e.want.face));
            if (got.tex_x !== e.want.tex_x)
                report($sformatf("%s tex_x %0d exp %0d", tag, got.tex_x, e.want.tex_x));
            if (got.tex_y !== e.want.tex_y)
                report($sformatf("%s tex_y %0d exp %0d", tag, got.tex_y, e.want.tex_y));
            if (got.texel_index !== e.want.texel_index)
                report($sformatf("%s texel_index %0d exp %0d", tag, got.texel_index,
                                 e.want.texel_index));
            if (got.status !== e.want.status)
                report($sformatf("%s status %0d exp %0d", tag, got.status, e.want.status));
        endtask
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    cfts_req_t             req       = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    cfts_rsp_t             rsp;

    texel_scoreboard sb = new;

    int          burst_left  = 0;
    bit          quiet       = 1'b0;
    int          idle_cycles = 0;
    ready_mode_t ready_mode  = RDY_ALWAYS;
    int          ready_left  = 0;
    int          ready_tick  = 0;

    cubemap_face_texel_select dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // receiver backpressure: pick a new ready pattern whenever the current one runs out
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_left = $urandom_range(20, 120);
        end
        ready_left--;
        ready_tick++;
        case (ready_mode)
            RDY_ALWAYS:   rsp_ready <= 1'b1;
            RDY_COIN:     rsp_ready <= ($urandom_range(0, 1) != 0);
            RDY_PERIODIC: rsp_ready <= ((ready_tick % 5) != 0);
            default:      rsp_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_response(rsp);
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("cubemap_face_texel_select regression: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_request(cfts_req_t item);
        int gap;
        if (burst_left == 0)
        begin
            gap = quiet ? 0 : $urandom_range(0, 6);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        req_valid <= 1'b1;
        req       <= item;
        do @(posedge clk); while (!req_ready);
        sb.note_request(item);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic set_config(int unsigned width, int unsigned count);
        cfg_valid <= 1'b1;
        cfg_index <= REG_FACE_WIDTH;
        cfg_data  <= CFG_DATA_W'(width);
        do @(posedge clk); while (!cfg_ready);
        sb.fw_reg = width & 32'h1FFF;
        cfg_index <= REG_MIP_COUNT;
        cfg_data  <= CFG_DATA_W'(count);
        do @(posedge clk); while (!cfg_ready);
        sb.mc_reg = count & 32'h1F;
        cfg_valid <= 1'b0;
    endtask

    task automatic direct(int x, int y, int z, int mip);
        cfts_req_t r;
        r.dir_x     = DIR_W'(x);
        r.dir_y     = DIR_W'(y);
        r.dir_z     = DIR_W'(z);
        r.mip_level = MIP_W'(mip);
        send_request(r);
    endtask

    function automatic int comp_within(int m);
        int v;
        v = int'($urandom_range(0, 2 * m));
        return v - m;
    endfunction

    function automatic int signed_mag(int m);
        return ($urandom_range(0, 1) != 0) ? m : -m;
    endfunction

    function automatic cfts_req_t make_request();
        cfts_req_t   r;
        int          d[3];
        int          kind;
        int          m;
        int          axis;
        int unsigned mc;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3:
            begin
                for (int i = 0; i < 3; i++)
                    d[i] = $urandom;
            end
            4:
            begin
                for (int i = 0; i < 3; i++)
                    d[i] = comp_within(4);
            end
            5, 6, 7:
            begin
                // one dominant axis, tied with another axis always for kind 5 and half the time otherwise
                m    = (kind == 7) ? $urandom_range(1, 64) : $urandom_range(1, 32768);
                axis = $urandom_range(0, 2);
                for (int i = 0; i < 3; i++)
                    d[i] = comp_within(m);
                d[axis] = signed_mag(m);
                if (kind == 5 || $urandom_range(0, 1) != 0)
                    d[(axis + 1 + $urandom_range(0, 1)) % 3] = signed_mag(m);
            end
            8:
            begin
                d[0] = 0;
                d[1] = 0;
                d[2] = 0;
            end
            default:
            begin
                for (int i = 0; i < 3; i++)
                    d[i] = $urandom;
                d[$urandom_range(0, 2)] = -32768;
            end
        endcase
        r.dir_x = DIR_W'(d[0]);
        r.dir_y = DIR_W'(d[1]);
        r.dir_z = DIR_W'(d[2]);
        mc = (sb.mc_reg > MAX_MIP_LEVELS) ? MAX_MIP_LEVELS : sb.mc_reg;
        if (mc != 0 && $urandom_range(0, 3) != 0)
            r.mip_level = MIP_W'($urandom_range(0, mc - 1));
        else
            r.mip_level = MIP_W'($urandom_range(0, 15));
        return r;
    endfunction

    initial
    begin
        int unsigned fw;
        int unsigned mc;
        int          n;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every face, ties, zero direction, extremes, mip range (reset config)
        direct(100, 0, 0, 0);
        direct(-100, 0, 0, 0);
        direct(0, 100, 0, 0);
        direct(0, -100, 0, 0);
        direct(0, 0, 100, 0);
        direct(0, 0, -100, 0);
        direct(0, 0, 0, 0);
        direct(0, 0, 0, 15);
        direct(5, 5, 5, 0);
        direct(-7, 7, 3, 0);
        direct(0, -9, 9, 0);
        direct(32767, 32767, -32767, 0);
        direct(-32768, 32767, 32767, 0);
        direct(32767, -32768, 0, 0);
        direct(0, 0, -32768, 0);
        direct(1, -1, 1, 0);
        direct(1, 0, 0, 1);
        direct(-20, 20, -20, 0);
        direct(32767, 0, 0, 0);
        direct(1, 0, 0, 0);
        direct(-1, -1, -1, 0);
        direct(-32768, -32768, -32768, 0);

        for (int p = 0; p < 10; p++)
        begin
            case (p)
                0: begin fw = 4096; mc = 16;       end
                1: begin fw = 1;    mc = 1;        end
                2: begin fw = 8191; mc = 31;       end
                3: begin fw = 0;    mc = 0;        end
                4: begin fw = 4097; mc = 17;       end
                5: begin fw = 3;    mc = 13'h1FE8; end
                6: begin fw = 257;  mc = 2;        end
                7: begin fw = 4095; mc = 15;       end
                default:
                begin
                    fw = $urandom_range(1, 4096);
                    mc = $urandom_range(1, 16);
                end
            endcase
            drain();
            set_config(fw, mc);
            quiet = (p % 3 == 1);
            n = ((mc & 32'h1F) == 0) ? 40 : 168;
            for (int i = 0; i < n; i++)
            begin
                if (p == 2 && i == n / 2)
                    drain();
                send_request(make_request());
            end
        end

        drain();
        repeat (SETTLE_WAIT) @(posedge clk);
        if (sb.errors == 0)
            $display("cubemap_face_texel_select regression: pass");
        else
            $display("cubemap_face_texel_select regression: fail");
        $finish;
    end
endmodule
